// ===== sv/radix_digit_converter_top_assert.svh =====
// ---------------------------------------------------------------------------
// radix_digit_converter_top_assert.svh
// Assertion macros shared by the radix digit converter modules.
// ---------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_TOP_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication, checked at every rising clk edge outside reset
`define RDC_AST_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdc assertion failed");

// next-cycle implication
`define RDC_AST_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdc assertion failed");

`endif

// ===== sv/rdc_pkg.sv =====
// ---------------------------------------------------------------------------
// rdc_pkg
// Sizes, state encoding and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdc_pkg;

	localparam int VALUE_BITS = 31;
	localparam int MAX_DIGITS = 31;
	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = 4;
	localparam int CHUNK_BITS = 8;
	localparam int DIV_STEPS  = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int PAD_BITS   = DIV_STEPS * CHUNK_BITS;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic step_end;
		logic quot_zero;
		logic one_left;
	} sts_t;

endpackage

// ===== sv/rdc_ctrl.sv =====
// ---------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: load, repeated division one chunk per cycle, digit emission.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radix_digit_converter_top_assert.svh"

module rdc_ctrl import rdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.step_end && sts.quot_zero) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready && sts.one_left) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.pop   = out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	`RDC_AST_IMP(a_no_overlap, in_ready, !out_valid)
	`RDC_AST_NXT(a_in_to_div, in_valid && in_ready, state_q == ST_DIV)
	`RDC_AST_NXT(a_last_to_idle, out_valid && out_ready && sts.one_left, in_ready)
	`RDC_AST_IMP(a_emit_has_digit, out_valid, !cmd.step)

endmodule

// ===== sv/rdc_dp.sv =====
// ---------------------------------------------------------------------------
// rdc_dp
// Datapath: chunked restoring division by the radix and a digit stack.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radix_digit_converter_top_assert.svh"

module rdc_dp import rdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic [DIGIT_W-1:0]    digit,
	output logic                  last
);

	logic [PAD_BITS-1:0]   work_q, work_d;
	logic [RADIX_W-1:0]    radix_q;
	logic [DIGIT_W-1:0]    rem_q, rem_d;
	logic [STEP_W-1:0]     step_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIGIT_W-1:0]    stk_q [MAX_DIGITS];
	logic [CHUNK_BITS-1:0] qbits;
	logic [RADIX_W-1:0]    rad_clamp;

	always_comb begin
		if (radix < RADIX_W'(2)) rad_clamp = RADIX_W'(2);
		else if (radix > RADIX_W'(16)) rad_clamp = RADIX_W'(16);
		else rad_clamp = radix;
	end

	always_comb begin
		logic [RADIX_W-1:0] t;
		logic [DIGIT_W-1:0] r;
		r = rem_q;
		qbits = '0;
		for (int i = 0; i < CHUNK_BITS; i++) begin
			t = {r, work_q[PAD_BITS-1-i]};
			if (t >= radix_q) begin
				qbits[CHUNK_BITS-1-i] = 1'b1;
				t = t - radix_q;
			end
			r = t[DIGIT_W-1:0];
		end
		rem_d  = r;
		work_d = (work_q << CHUNK_BITS) | PAD_BITS'(qbits);
	end

	assign sts.step_end  = (step_q == STEP_W'(DIV_STEPS - 1));
	assign sts.quot_zero = (work_d == '0);
	assign sts.one_left  = (cnt_q == CNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q  <= PAD_BITS'(value);
			radix_q <= rad_clamp;
			rem_q   <= '0;
		end else if (cmd.step) begin
			work_q <= work_d;
			rem_q  <= sts.step_end ? '0 : rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.step) begin
			step_q <= sts.step_end ? '0 : step_q + STEP_W'(1);
			if (sts.step_end && cnt_q < CNT_W'(MAX_DIGITS)) cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// push: newest at the top, older digits move down; pop moves them back up
	always_ff @(posedge clk) begin
		if (cmd.step && sts.step_end && cnt_q < CNT_W'(MAX_DIGITS)) begin
			for (int i = 0; i < MAX_DIGITS - 1; i++) stk_q[i] <= stk_q[i+1];
			stk_q[MAX_DIGITS-1] <= rem_d;
		end else if (cmd.pop) begin
			for (int i = 0; i < MAX_DIGITS - 1; i++) stk_q[i+1] <= stk_q[i];
		end
	end

	assign digit = stk_q[MAX_DIGITS-1];
	assign last  = sts.one_left;

	`RDC_AST_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_DIGITS))
	`RDC_AST_IMP(a_pop_nonempty, cmd.pop, cnt_q != '0)
	`RDC_AST_NXT(a_load_clears, cmd.load, cnt_q == '0 && step_q == '0)

endmodule

// ===== sv/radix_digit_converter_top.sv =====
// ---------------------------------------------------------------------------
// radix_digit_converter_top
// Integer to radix 2..16 digits by repeated division, MSD first.
//
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    value[30:0], radix[4:0]
// out      out  out_valid/out_ready  digit[3:0], last
//
// Per item: one load, then N divider passes and N output transfers,
// N = digit count (1..31); each pass takes 8 quotient bits per cycle
// over the padded 32-bit value. Output transfers can be stalled.
// One item at a time; in_ready is high only while idle.
// Reset clears the sequencer and counters; the digit stack needs none.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_digit_converter_top import rdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DIGIT_W-1:0]    digit,
	output logic                  last
);

	cmd_t cmd;
	sts_t sts;

	rdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rdc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (value),
		.radix  (radix),
		.cmd    (cmd),
		.sts    (sts),
		.digit  (digit),
		.last   (last)
	);

endmodule

// ===== tb/sv/radix_digit_converter_checker.sv =====
// ---------------------------------------------------------------------------
// radix_digit_converter_checker
// Watches both channels of the radix digit converter. Each input transfer
// is turned into its expected digit sequence, most significant first, and
// every output transfer is compared field by field against the oldest
// outstanding digit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_digit_converter_checker import rdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [DIGIT_W-1:0]    digit,
	input  logic                  last,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} digit_rec_t;

	digit_rec_t expected_digits[$];
	int         fails = 0;
	int         outstanding = 0;

	assign fail_count = fails;
	assign pending    = outstanding;

	function automatic void predict_digits(input logic [VALUE_BITS-1:0] v_in,
			input logic [RADIX_W-1:0] r_in);
		logic [VALUE_BITS-1:0] v;
		logic [VALUE_BITS-1:0] base;
		logic [DIGIT_W-1:0]    lsd_first [MAX_DIGITS];
		int                    count;
		digit_rec_t            rec;
		v     = v_in;
		base  = VALUE_BITS'(r_in);
		count = 0;
		if (r_in < RADIX_W'(2)) begin
			base = VALUE_BITS'(2);
		end else if (r_in > RADIX_W'(16)) begin
			base = VALUE_BITS'(16);
		end
		do begin
			if (count < MAX_DIGITS) begin
				lsd_first[count] = DIGIT_W'(v % base);
				count++;
			end
			v = v / base;
		end while (v != '0);
		for (int k = count - 1; k >= 0; k--) begin
			rec.digit = lsd_first[k];
			rec.last  = (k == 0);
			expected_digits.push_back(rec);
		end
	endfunction

	always @(posedge clk) begin
		digit_rec_t want;
		int         errs;
		errs = 0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_digits.size() == 0) begin
					$display("%0t unexpected transfer: expected none, actual digit %0h last %0b",
						$time, digit, last);
					errs++;
				end else begin
					want = expected_digits.pop_front();
					if (digit !== want.digit) begin
						$display("%0t digit mismatch: expected %0h actual %0h",
							$time, want.digit, digit);
						errs++;
					end
					if (last !== want.last) begin
						$display("%0t last mismatch: expected %0b actual %0b",
							$time, want.last, last);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_digits(value, radix);
			end
			fails       <= fails + errs;
			outstanding <= expected_digits.size();
		end
	end

endmodule

// ===== tb/sv/radix_digit_converter_top_tb.sv =====
// ---------------------------------------------------------------------------
// radix_digit_converter_top_tb
// Stimulus and verdict for the radix digit converter. A directed set covers
// zero, the full-scale value, several radixes including the clamped ones, and
// digit-count boundaries; a random set follows with mixed value shapes.
// Both sides idle at random, the receiver holds off once for a long
// stretch, and the sender pauses once until all digits have drained.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_digit_converter_top_tb;
	import rdc_pkg::*;

	localparam int RANDOM_ITEMS = 290;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 400;
	localparam int PAUSE_AT     = 240;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 600000;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [VALUE_BITS-1:0] value     = '0;
	logic [RADIX_W-1:0]    radix     = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [DIGIT_W-1:0]    digit;
	logic                  last;
	int                    fail_count;
	int                    pending;
	int                    sent = 0;
	bit                    calm = 1'b0;

	radix_digit_converter_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.radix     (radix),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.digit     (digit),
		.last      (last)
	);

	radix_digit_converter_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.radix      (radix),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit      (digit),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [VALUE_BITS-1:0] v, input logic [RADIX_W-1:0] r);
		in_valid <= 1'b1;
		value    <= v;
		radix    <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		if (!calm && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8) << $urandom_range(0, 3)) @(posedge clk);
		end
	endtask

	initial begin : receiver
		bit held;
		held = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (!held && sent >= HOLD_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(99) >= 24);
		end
	end

	initial begin : sender
		logic [VALUE_BITS-1:0] v;
		logic [RADIX_W-1:0]    r;
		longint unsigned       p;
		longint unsigned       b;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_item('0, 5'd2);
		send_item('0, 5'd16);
		send_item('0, 5'd10);
		send_item(31'd1, 5'd2);
		send_item('1, 5'd2);
		send_item('1, 5'd16);
		send_item('1, 5'd10);
		send_item('1, 5'd3);
		send_item(31'h4000_0000, 5'd2);
		send_item(31'd15, 5'd16);
		send_item(31'd16, 5'd16);
		send_item(31'd255, 5'd16);
		send_item(31'd6, 5'd7);
		send_item(31'd7, 5'd7);
		send_item(31'd9, 5'd10);
		send_item(31'd10, 5'd10);
		// out-of-range radix values clamp to 2 or 16
		send_item(31'd1, 5'd0);
		send_item(31'd5, 5'd1);
		send_item(31'd300, 5'd17);
		send_item(31'd300, 5'd31);
		send_item('1, 5'd31);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 100 && n < 150);
			if (n == PAUSE_AT) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if ($urandom_range(9) == 0) begin
				r = RADIX_W'($urandom_range(0, 31));
			end else begin
				r = RADIX_W'($urandom_range(2, 16));
			end
			case ($urandom_range(3))
				0: v = VALUE_BITS'($urandom);
				1: v = VALUE_BITS'($urandom_range(0, 300));
				2: v = VALUE_BITS'($urandom >> $urandom_range(1, 31));
				default: begin
					b = (r < 2) ? 2 : (r > 16) ? 16 : r;
					p = 1;
					repeat ($urandom_range(1, 30)) begin
						if (p * b < 64'h8000_0000) p = p * b;
					end
					v = VALUE_BITS'(p - $urandom_range(0, 1));
				end
			endcase
			send_item(v, r);
		end

		calm = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== radix_digit_converter_top.f =====
+incdir+sv
sv/rdc_pkg.sv
sv/rdc_ctrl.sv
sv/rdc_dp.sv
sv/radix_digit_converter_top.sv
tb/sv/radix_digit_converter_checker.sv
tb/sv/radix_digit_converter_top_tb.sv
